// ===== sv/cbs_pkg.sv =====
// shared types and constants of the container box scanner
`default_nettype none

package cbs_pkg;

  localparam int POS_WIDTH_DEF = 40;
  localparam int OFF_W = 40;
  localparam int LEN_W = 40;
  localparam int TYPE_W = 32;
  localparam int LARGE_W = 64;
  localparam int HB_W = 5;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int REG_SHIFT = 3;

  localparam logic [HB_W-1:0] SIZE_BYTES = 5'd4;
  localparam logic [HB_W-1:0] HDR_SHORT = 5'd8;
  localparam logic [HB_W-1:0] HDR_LONG = 5'd16;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_MALFORMED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_TARGET_TYPE   = 2'd0,
    REG_REGION_BASE   = 2'd1,
    REG_REGION_LENGTH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_first;
  } req_t;

  typedef struct packed {
    status_t          scan_status;
    logic [OFF_W-1:0] header_offset;
    logic [OFF_W-1:0] payload_offset;
    logic [OFF_W-1:0] payload_size;
    logic [OFF_W-1:0] total_size;
  } rsp_t;

  typedef struct packed {
    logic [TYPE_W-1:0] target_type;
    logic [OFF_W-1:0]  region_base;
    logic [LEN_W-1:0]  region_length;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/container_box_scanner.sv =====
// top level of the container box scanner
//
// walks the iso bmff boxes of one region, one byte per request on the req
// channel (valid/ready, payload req_data), and gives one result per search
// on the rsp channel (valid/ready, payload rsp_data): box found with its
// offsets and sizes, region exhausted, or malformed box. after the result
// later bytes give nothing until a request with region_first set.
// configuration (target_type, region_base, region_length) sits on the apb
// port at byte addresses 0, 8 and 16, 64-bit data; write only while idle.
// throughput: one byte per cycle while a stalled result does not block the
// step; each byte's step is one pass of logic from the request register
// to the result register, which registers a result when one is given.
// reset: synchronous; all registers but req_hold and rsp_data clear to
// zero and the scan starts as if a region had begun. when the receiver
// stalls, the result is held and one more request is held in the request
// register; req_ready then drops.
`default_nettype none

module container_box_scanner #(
  parameter int POS_WIDTH = cbs_pkg::POS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  cbs_pkg::req_t               req_data,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output cbs_pkg::rsp_t               rsp_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbs_pkg::ADDR_W-1:0]  paddr,
  input  logic [cbs_pkg::DATA_W-1:0]  pwdata,
  output logic [cbs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import cbs_pkg::*;

  cfg_t cfg;
  req_t req_hold;
  logic req_hold_valid;
  logic advance;
  logic emit;
  rsp_t rsp_step;

  assign advance   = req_hold_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_hold_valid || advance;

  cbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbs_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (req_hold),
    .cfg  (cfg),
    .emit (emit),
    .rsp  (rsp_step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_hold_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      req_hold_valid <= 1'b1;
    end else if (advance) begin
      req_hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_hold <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= emit;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      rsp_data <= rsp_step;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbs_regs.sv =====
// configuration register file behind the apb port
`default_nettype none

module cbs_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbs_pkg::ADDR_W-1:0]  paddr,
  input  logic [cbs_pkg::DATA_W-1:0]  pwdata,
  output logic [cbs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cbs_pkg::cfg_t               cfg
);
  import cbs_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:REG_SHIFT]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET_TYPE:   cfg.target_type <= pwdata[TYPE_W-1:0];
        REG_REGION_BASE:   cfg.region_base <= pwdata[OFF_W-1:0];
        REG_REGION_LENGTH: cfg.region_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET_TYPE:   prdata = DATA_W'(cfg.target_type);
      REG_REGION_BASE:   prdata = DATA_W'(cfg.region_base);
      REG_REGION_LENGTH: prdata = DATA_W'(cfg.region_length);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/cbs_core.sv =====
// box walking state and per-byte step logic
`default_nettype none

module cbs_core #(
  parameter int POS_WIDTH = cbs_pkg::POS_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  cbs_pkg::req_t req,
  input  cbs_pkg::cfg_t cfg,
  output logic          emit,
  output cbs_pkg::rsp_t rsp
);
  import cbs_pkg::*;

  localparam int CW = ((POS_WIDTH > LEN_W) ? POS_WIDTH : LEN_W) + 2;
  localparam int AW = (POS_WIDTH > OFF_W) ? POS_WIDTH : OFF_W;
  localparam int SW = LARGE_W + 2;

  logic [POS_WIDTH-1:0] byte_position, byte_position_next;
  logic [POS_WIDTH-1:0] box_start, box_start_next;
  logic [POS_WIDTH-1:0] box_end, box_end_next;
  logic [HB_W-1:0]      header_bytes_seen, header_bytes_seen_next;
  logic [31:0]          short_size, short_size_next;
  logic [TYPE_W-1:0]    box_kind, box_kind_next;
  logic [LARGE_W-1:0]   large_size, large_size_next;
  logic                 search_done, search_done_next;

  // state as seen by this byte, after a region restart
  logic [POS_WIDTH-1:0] pos_e, bs_e, be_e, pos_inc;
  logic [HB_W-1:0]      hb_e, hb_inc, hdr_len;
  logic [31:0]          ss_e, ss_new;
  logic [TYPE_W-1:0]    kind_e, kind_new;
  logic [LARGE_W-1:0]   ls_e, ls_new, size_val;
  logic                 done_e, in_header, bs_le_len, malformed, match;
  logic                 fits8_bs, fits16_bs, fits8_be, fits8_end, past_end;
  logic [CW-1:0]        avail;
  logic [SW-1:0]        end_sum;
  logic [POS_WIDTH-1:0] eval_end, h_pos, p_pos;

  assign pos_e  = req.region_first ? '0 : byte_position;
  assign bs_e   = req.region_first ? '0 : box_start;
  assign be_e   = req.region_first ? '0 : box_end;
  assign hb_e   = req.region_first ? '0 : header_bytes_seen;
  assign ss_e   = req.region_first ? '0 : short_size;
  assign kind_e = req.region_first ? '0 : box_kind;
  assign ls_e   = req.region_first ? '0 : large_size;
  assign done_e = req.region_first ? 1'b0 : search_done;

  assign pos_inc = pos_e + POS_WIDTH'(1);
  assign hb_inc  = hb_e + HB_W'(1);
  assign hdr_len = (hb_inc == HDR_LONG) ? HDR_LONG : HDR_SHORT;

  assign in_header = (hb_e < HDR_SHORT) || ((hb_e < HDR_LONG) && (ss_e == 32'd1));
  assign ss_new   = (hb_e < SIZE_BYTES) ? {ss_e[23:0], req.data_byte} : ss_e;
  assign kind_new = ((hb_e >= SIZE_BYTES) && (hb_e < HDR_SHORT)) ?
                    {kind_e[TYPE_W-9:0], req.data_byte} : kind_e;
  assign ls_new   = (hb_e >= HDR_SHORT) ? {ls_e[LARGE_W-9:0], req.data_byte} : ls_e;

  assign past_end  = CW'(pos_e) >= CW'(cfg.region_length);
  assign fits8_bs  = (CW'(bs_e) + CW'(HDR_SHORT)) <= CW'(cfg.region_length);
  assign fits16_bs = (CW'(bs_e) + CW'(HDR_LONG)) <= CW'(cfg.region_length);
  assign fits8_be  = (CW'(be_e) + CW'(HDR_SHORT)) <= CW'(cfg.region_length);
  assign bs_le_len = CW'(bs_e) <= CW'(cfg.region_length);
  assign avail     = CW'(cfg.region_length) - CW'(bs_e);

  always_comb begin
    if (ss_new == 32'd0) begin
      size_val = bs_le_len ? LARGE_W'(avail) : '0;
    end else if (ss_new == 32'd1) begin
      size_val = ls_new;
    end else begin
      size_val = LARGE_W'(ss_new);
    end
  end

  assign end_sum   = SW'(bs_e) + SW'(size_val);
  assign eval_end  = end_sum[POS_WIDTH-1:0];
  assign malformed = (size_val < LARGE_W'(hdr_len)) || (end_sum > SW'(cfg.region_length));
  assign match     = kind_new == cfg.target_type;
  assign fits8_end = (CW'(eval_end) + CW'(HDR_SHORT)) <= CW'(cfg.region_length);

  assign h_pos = POS_WIDTH'(AW'(cfg.region_base) + AW'(bs_e));
  assign p_pos = h_pos + POS_WIDTH'(hdr_len);

  always_comb begin
    byte_position_next     = byte_position;
    box_start_next         = box_start;
    box_end_next           = box_end;
    header_bytes_seen_next = header_bytes_seen;
    short_size_next        = short_size;
    box_kind_next          = box_kind;
    large_size_next        = large_size;
    search_done_next       = search_done;
    emit                   = 1'b0;
    rsp                    = '0;
    rsp.scan_status        = STATUS_EXHAUSTED;
    if (step) begin
      byte_position_next     = pos_e;
      box_start_next         = bs_e;
      box_end_next           = be_e;
      header_bytes_seen_next = hb_e;
      short_size_next        = ss_e;
      box_kind_next          = kind_e;
      large_size_next        = ls_e;
      search_done_next       = done_e;
      if (!done_e) begin
        if (past_end || ((hb_e == '0) && !fits8_bs)) begin
          emit = 1'b1;
        end else if (in_header) begin
          short_size_next        = ss_new;
          box_kind_next          = kind_new;
          large_size_next        = ls_new;
          header_bytes_seen_next = hb_inc;
          byte_position_next     = pos_inc;
          if ((hb_inc == HDR_SHORT) && (ss_new == 32'd1)) begin
            emit = !fits16_bs;
          end else if ((hb_inc == HDR_SHORT) || (hb_inc == HDR_LONG)) begin
            if (malformed) begin
              emit = 1'b1;
              rsp.scan_status = STATUS_MALFORMED;
            end else if (match) begin
              emit = 1'b1;
              rsp.scan_status    = STATUS_FOUND;
              rsp.header_offset  = OFF_W'(AW'(h_pos));
              rsp.payload_offset = OFF_W'(AW'(p_pos));
              rsp.payload_size   = OFF_W'(size_val - LARGE_W'(hdr_len));
              rsp.total_size     = OFF_W'(size_val);
            end else begin
              box_end_next = eval_end;
              if (size_val == LARGE_W'(hdr_len)) begin
                box_start_next         = eval_end;
                header_bytes_seen_next = '0;
                short_size_next        = '0;
                box_kind_next          = '0;
                large_size_next        = '0;
                emit                   = !fits8_end;
              end
            end
          end
        end else begin
          byte_position_next = pos_inc;
          if (pos_inc == be_e) begin
            box_start_next         = be_e;
            header_bytes_seen_next = '0;
            short_size_next        = '0;
            box_kind_next          = '0;
            large_size_next        = '0;
            emit                   = !fits8_be;
          end
        end
        if (emit) begin
          search_done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      box_start         <= '0;
      box_end           <= '0;
      header_bytes_seen <= '0;
      short_size        <= '0;
      box_kind          <= '0;
      large_size        <= '0;
      search_done       <= 1'b0;
    end else begin
      byte_position     <= byte_position_next;
      box_start         <= box_start_next;
      box_end           <= box_end_next;
      header_bytes_seen <= header_bytes_seen_next;
      short_size        <= short_size_next;
      box_kind          <= box_kind_next;
      large_size        <= large_size_next;
      search_done       <= search_done_next;
    end
  end

  // one result per search
  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> search_done)
    else $error("search not closed after result");

  a_no_emit_when_done: assert property (@(posedge clk) disable iff (rst)
    step && emit |-> (!search_done || req.region_first))
    else $error("result from a finished search");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    !(header_bytes_seen > HDR_LONG))
    else $error("header byte count out of range");

  a_found_sizes: assert property (@(posedge clk) disable iff (rst)
    step && emit && (rsp.scan_status == STATUS_FOUND) |->
      ((rsp.total_size == rsp.payload_size + OFF_W'(HDR_SHORT)) ||
       (rsp.total_size == rsp.payload_size + OFF_W'(HDR_LONG))))
    else $error("found box sizes disagree");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the container box scanner: byte stream in, scan results out
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbs_pkg::*;

  localparam logic [63:0] M32 = 64'hFFFF_FFFF;
  localparam logic [63:0] M40 = 64'hFF_FFFF_FFFF;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned ITEMS = 1200;
  localparam int unsigned MAX_REGIONS = 400;
  localparam logic [31:0] KIND_MOOV = 32'h6D6F_6F76;
  localparam logic [31:0] KIND_FREE = 32'h6672_6565;
  localparam logic [31:0] KIND_MDAT = 32'h6D64_6174;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  container_box_scanner dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  class box_scoreboard;
    logic [31:0] target;
    logic [63:0] base;
    logic [63:0] rlen;
    logic [63:0] pos;
    logic [63:0] box_start;
    logic [63:0] box_end;
    logic [63:0] short_size;
    logic [63:0] box_kind;
    logic [63:0] large_size;
    int unsigned hdr_seen;
    bit done;
    rsp_t expected_q[$];
    int unsigned mismatches;
    int unsigned scanned;
    int unsigned checked;
    int unsigned found;
    int unsigned exhausted;
    int unsigned malformed;

    function new();
      target = '0;
      base = '0;
      rlen = '0;
      pos = '0;
      box_start = '0;
      box_end = '0;
      short_size = '0;
      box_kind = '0;
      large_size = '0;
      hdr_seen = 0;
      done = 1'b0;
      mismatches = 0;
      scanned = 0;
      checked = 0;
      found = 0;
      exhausted = 0;
      malformed = 0;
    endfunction

    function void configure(reg_idx_t idx, logic [63:0] value);
      case (idx)
        REG_TARGET_TYPE: target = value[31:0];
        REG_REGION_BASE: base = value & M40;
        REG_REGION_LENGTH: rlen = value & M40;
        default: ;
      endcase
    endfunction

    function bit room(logic [63:0] at, logic [63:0] n);
      return n <= rlen && at <= rlen - n;
    endfunction

    function void conclude(status_t st, logic [63:0] hdr, logic [63:0] box_size);
      rsp_t r;
      logic [39:0] h;
      done = 1'b1;
      r = '0;
      r.scan_status = st;
      if (st == STATUS_FOUND) begin
        h = base[39:0] + box_start[39:0];
        r.header_offset = h;
        r.payload_offset = h + hdr[39:0];
        r.payload_size = box_size[39:0] - hdr[39:0];
        r.total_size = box_size[39:0];
      end
      expected_q = {expected_q, r};
    endfunction

    function void open_box();
      box_start = box_end;
      hdr_seen = 0;
      short_size = '0;
      box_kind = '0;
      large_size = '0;
      if (!room(box_start, 64'(HDR_SHORT))) conclude(STATUS_EXHAUSTED, '0, '0);
    endfunction

    function void judge(logic [63:0] hdr);
      logic [63:0] box_size;
      if (short_size == 0) box_size = (box_start <= rlen) ? rlen - box_start : '0;
      else if (short_size == 1) box_size = large_size;
      else box_size = short_size;
      if (box_size < hdr || box_start > rlen || box_size > rlen - box_start) begin
        conclude(STATUS_MALFORMED, '0, '0);
      end else if (box_kind[31:0] == target) begin
        conclude(STATUS_FOUND, hdr, box_size);
      end else begin
        box_end = (box_start + box_size) & M40;
        hdr_seen = int'(hdr);
        if (box_size == hdr) open_box();
      end
    endfunction

    function void note_request(req_t r);
      if (r.region_first) begin
        pos = '0;
        box_start = '0;
        box_end = '0;
        hdr_seen = 0;
        short_size = '0;
        box_kind = '0;
        large_size = '0;
        done = 1'b0;
      end
      if (done) return;
      scanned++;
      if (pos >= rlen) begin
        conclude(STATUS_EXHAUSTED, '0, '0);
        return;
      end
      if (hdr_seen == 0 && !room(box_start, 64'(HDR_SHORT))) begin
        conclude(STATUS_EXHAUSTED, '0, '0);
        return;
      end
      if (hdr_seen < HDR_SHORT || (hdr_seen < HDR_LONG && short_size == 1)) begin
        if (hdr_seen < SIZE_BYTES) short_size = ((short_size << 8) | r.data_byte) & M32;
        else if (hdr_seen < HDR_SHORT) box_kind = ((box_kind << 8) | r.data_byte) & M32;
        else large_size = (large_size << 8) | r.data_byte;
        hdr_seen++;
        pos = (pos + 1) & M40;
        if (hdr_seen == HDR_SHORT) begin
          if (short_size == 1) begin
            if (!room(box_start, 64'(HDR_LONG))) conclude(STATUS_EXHAUSTED, '0, '0);
          end else begin
            judge(64'(HDR_SHORT));
          end
        end else if (hdr_seen == HDR_LONG) begin
          judge(64'(HDR_LONG));
        end
      end else begin
        pos = (pos + 1) & M40;
        if (pos == box_end) open_box();
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      bit bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d hdr %h pay %h psize %h total %h",
                   got.scan_status, got.header_offset, got.payload_offset,
                   got.payload_size, got.total_size);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      case (want.scan_status)
        STATUS_FOUND: found++;
        STATUS_EXHAUSTED: exhausted++;
        default: malformed++;
      endcase
      bad = got.scan_status !== want.scan_status ||
            got.header_offset !== want.header_offset ||
            got.payload_offset !== want.payload_offset ||
            got.payload_size !== want.payload_size ||
            got.total_size !== want.total_size;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d differs: expected %0d/%h/%h/%h/%h got %0d/%h/%h/%h/%h",
                   checked, want.scan_status, want.header_offset, want.payload_offset,
                   want.payload_size, want.total_size, got.scan_status,
                   got.header_offset, got.payload_offset, got.payload_size,
                   got.total_size);
      end
    endfunction
  endclass

  box_scoreboard sb;
  logic [7:0] region_q[$];
  logic [31:0] kind_pool[4];
  int unsigned burst_left;
  int unsigned regions_sent;
  int unsigned sent_items;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      if (req_valid && req_ready) sb.note_request(req_data);
    end
  end

  task automatic offer(input logic [7:0] data, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(60, 200);
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 8);
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    sent_items++;
    req_valid <= 1'b1;
    req_data.data_byte <= data;
    req_data.region_first <= first;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << REG_SHIFT;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.configure(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) region_q = {region_q, v[8*i +: 8]};
  endtask

  task automatic send_region(input bit first);
    foreach (region_q[i]) offer(region_q[i], (i == 0) ? first : ($urandom_range(0, 99) == 0));
  endtask

  task automatic add_box(input logic [31:0] target);
    int unsigned roll;
    int unsigned pay;
    logic [31:0] kind;
    logic [63:0] big;
    roll = $urandom_range(0, 99);
    kind = ($urandom_range(0, 3) == 0) ? target : kind_pool[$urandom_range(0, 3)];
    if (roll < 55) begin
      pay = $urandom_range(0, 16);
      push_be(64'(8 + pay), 4);
      push_be(64'(kind), 4);
    end else if (roll < 72) begin
      big = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : 64'(16 + $urandom_range(0, 16));
      pay = (big >= 16 && big <= 32) ? 32'(big - 16) : $urandom_range(0, 4);
      push_be(64'd1, 4);
      push_be(64'(kind), 4);
      push_be(big, 8);
    end else if (roll < 80) begin
      pay = $urandom_range(0, 20);
      push_be(64'd0, 4);
      push_be(64'(kind), 4);
    end else if (roll < 90) begin
      // header length larger than the box itself
      if ($urandom_range(0, 1) == 1) begin
        push_be(64'($urandom_range(2, 7)), 4);
        push_be(64'(kind), 4);
      end else begin
        push_be(64'd1, 4);
        push_be(64'(kind), 4);
        push_be(64'($urandom_range(0, 15)), 8);
      end
      pay = $urandom_range(0, 4);
    end else begin
      push_be(64'($urandom), 4);
      push_be(64'(kind), 4);
      pay = $urandom_range(0, 8);
    end
    repeat (pay) region_q = {region_q, 8'($urandom)};
  endtask

  task automatic run_region();
    logic [31:0] target;
    logic [63:0] base;
    logic [63:0] rlen;
    int unsigned len;
    int unsigned roll;
    int unsigned cut;
    roll = $urandom_range(0, 9);
    target = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
    kind_pool[0] = KIND_FREE;
    kind_pool[1] = KIND_MDAT;
    kind_pool[2] = $urandom;
    kind_pool[3] = target ^ (32'h1 << $urandom_range(0, 31));
    region_q.delete();
    repeat ($urandom_range(1, 4)) add_box(target);
    repeat ($urandom_range(0, 6)) region_q = {region_q, 8'($urandom)};
    len = region_q.size();
    roll = $urandom_range(0, 19);
    if (roll < 2) begin
      rlen = '0;
    end else if (roll == 2) begin
      rlen = M40;
    end else if (roll == 3) begin
      rlen = {$urandom, $urandom} & M40;
    end else if (roll < 10) begin
      rlen = 64'(len);
    end else if (roll < 15) begin
      cut = $urandom_range(1, 8);
      rlen = (len > cut) ? 64'(len - cut) : '0;
    end else begin
      rlen = 64'(len + $urandom_range(1, 16));
    end
    roll = $urandom_range(0, 9);
    if (roll == 0) base = '0;
    else if (roll == 1) base = M40;
    else if (roll == 2) base = M40 - 64'($urandom_range(0, 63));
    else base = {$urandom, $urandom} & M40;
    if (regions_sent == 0) begin
      target = 32'h0;
      base = M40;
      rlen = M40;
    end else if (regions_sent == 1) begin
      target = 32'hFFFF_FFFF;
      base = '0;
      rlen = '0;
    end
    settle();
    write_reg(REG_TARGET_TYPE, 64'(target));
    write_reg(REG_REGION_BASE, base);
    write_reg(REG_REGION_LENGTH, rlen);
    send_region($urandom_range(0, 19) != 0);
    regions_sent++;
  endtask

  initial begin
    int unsigned hold;
    int unsigned cycles;
    int unsigned next_hold;
    int unsigned mode;
    rsp_ready = 1'b0;
    cycles = 0;
    next_hold = 300;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        cycles++;
        if (cycles >= next_hold) begin
          // long hold-off so the block backs up into the request side
          hold = $urandom_range(150, 300);
          rsp_ready <= 1'b0;
          repeat (hold) @(negedge clk);
          cycles += hold;
          next_hold = cycles + 2000;
        end
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          2: rsp_ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    int unsigned drain;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sb = new();
    burst_left = 0;
    regions_sent = 0;
    sent_items = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // out of reset the length is zero, so the first byte exhausts the region
    offer(8'hA5, 1'b0);
    settle();
    write_reg(REG_TARGET_TYPE, 64'(KIND_MOOV));
    write_reg(REG_REGION_BASE, M40 - 64'd3);
    write_reg(REG_REGION_LENGTH, 64'd20);
    // match whose payload offset wraps, then a byte that is ignored
    region_q.delete();
    push_be(64'd8, 4);
    push_be(64'(KIND_MOOV), 4);
    region_q = {region_q, 8'h00};
    foreach (region_q[i]) offer(region_q[i], i == 0);
    // box smaller than its own header
    region_q.delete();
    push_be(64'd5, 4);
    push_be(64'(KIND_FREE), 4);
    foreach (region_q[i]) offer(region_q[i], i == 0);
    // length lowered below the next byte in the middle of a header
    region_q.delete();
    push_be(64'h100, 4);
    foreach (region_q[i]) offer(region_q[i], i == 0);
    settle();
    write_reg(REG_REGION_LENGTH, 64'd2);
    offer(8'hFF, 1'b0);

    while (sent_items < ITEMS && regions_sent < MAX_REGIONS)
      run_region();

    req_valid <= 1'b0;
    drain = 0;
    while (sb.expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d bytes (%0d scanned) in %0d random regions plus directed cases",
             sent_items, sb.scanned, regions_sent);
    $display("results compared: %0d (%0d found, %0d exhausted, %0d malformed)", sb.checked,
             sb.found, sb.exhausted, sb.malformed);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("container_box_scanner: match");
    end else begin
      $display("container_box_scanner: mismatch");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("container_box_scanner: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/cbs_pkg.sv
sv/cbs_regs.sv
sv/cbs_core.sv
sv/container_box_scanner.sv
dv/tb_top.sv
